// File: hdl/rpac_pkg.sv
// Shared constants, sine table and trig scaling for the point rotator.
package rpac_pkg;

  localparam int ANGLE_BITS   = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int QSINE_FRAC   = 16;
  localparam int QSINE_DEPTH  = 65;
  localparam int QSINE_IDX_W  = $clog2(QSINE_DEPTH);

  localparam logic [CFG_IDX_BITS-1:0] CFG_ANGLE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd2;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 8'd64;

  // Quarter-wave sine, Q1.16: round(65536*sin(k*pi/128)), k = 0..64
  localparam logic [QSINE_FRAC:0] QSINE [QSINE_DEPTH] = '{
    17'd0,     17'd1608,  17'd3216,  17'd4821,  17'd6424,  17'd8022,  17'd9616,  17'd11204,
    17'd12785, 17'd14359, 17'd15924, 17'd17479, 17'd19024, 17'd20557, 17'd22078, 17'd23586,
    17'd25080, 17'd26558, 17'd28020, 17'd29466, 17'd30893, 17'd32303, 17'd33692, 17'd35062,
    17'd36410, 17'd37736, 17'd39040, 17'd40320, 17'd41576, 17'd42806, 17'd44011, 17'd45190,
    17'd46341, 17'd47464, 17'd48559, 17'd49624, 17'd50660, 17'd51665, 17'd52639, 17'd53581,
    17'd54491, 17'd55368, 17'd56212, 17'd57022, 17'd57798, 17'd58538, 17'd59244, 17'd59914,
    17'd60547, 17'd61145, 17'd61705, 17'd62228, 17'd62714, 17'd63162, 17'd63572, 17'd63944,
    17'd64277, 17'd64571, 17'd64827, 17'd65043, 17'd65220, 17'd65358, 17'd65457, 17'd65516,
    17'd65536
  };

  // Rescale a Q1.16 magnitude to frac fraction bits, rounding half up on narrowing.
  function automatic logic [31:0] scale_trig(input logic [QSINE_FRAC:0] v,
                                             input int unsigned frac);
    logic [31:0] u;
    logic [31:0] half;
    int unsigned sh;
    u = {15'd0, v};
    if (frac >= QSINE_FRAC) begin
      return u << (frac - QSINE_FRAC);
    end
    sh   = QSINE_FRAC - frac;
    half = (32'd1 << sh) >> 1;
    return (u + half) >> sh;
  endfunction

endpackage

// File: hdl/rpac_trig.sv
// Sine and cosine of the rotation angle from the quarter-wave table.
module rpac_trig #(
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic [rpac_pkg::ANGLE_BITS-1:0] angle,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

  localparam int TW = TRIG_FRAC_BITS + 2;

  logic [rpac_pkg::ANGLE_BITS-1:0] cos_angle;

  assign cos_angle = rpac_pkg::ANGLE_BITS'(angle + rpac_pkg::QUARTER_TURN);

  function automatic logic signed [TW-1:0] wave(input logic [rpac_pkg::ANGLE_BITS-1:0] step);
    logic [1:0]                        quad;
    logic [rpac_pkg::QSINE_IDX_W-1:0]  idx;
    logic [31:0]                       mag;
    logic signed [TW-1:0]              sval;
    quad = step[7:6];
    // odd quadrants run the table backward
    if (quad[0]) begin
      idx = rpac_pkg::QSINE_IDX_W'(7'd64 - {1'b0, step[5:0]});
    end else begin
      idx = {1'b0, step[5:0]};
    end
    mag  = rpac_pkg::scale_trig(rpac_pkg::QSINE[idx], TRIG_FRAC_BITS);
    sval = signed'(mag[TW-1:0]);
    return quad[1] ? -sval : sval;
  endfunction

  assign sin_val = wave(angle);
  assign cos_val = wave(cos_angle);

endmodule

// File: hdl/rpac_rotate.sv
// Rotation arithmetic: products, sums, truncation toward zero and clipping.
module rpac_rotate #(
  parameter int COORD_BITS     = 24,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic signed [COORD_BITS:0]       ex,
  input  logic signed [COORD_BITS:0]       ey,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
  input  logic signed [COORD_BITS-1:0]     center_x,
  input  logic signed [COORD_BITS-1:0]     center_y,
  output logic signed [COORD_BITS-1:0]     rot_x,
  output logic signed [COORD_BITS-1:0]     rot_y,
  output logic                             sat
);

  localparam int EW = COORD_BITS + 1;
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = EW + TW;
  localparam int SW = COORD_BITS + TRIG_FRAC_BITS + 4;
  localparam int QW = SW - TRIG_FRAC_BITS;
  localparam logic [SW-1:0] BIAS = {{(SW-TRIG_FRAC_BITS){1'b0}}, {TRIG_FRAC_BITS{1'b1}}};
  localparam logic signed [COORD_BITS-1:0] HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [PW-1:0] p_xc, p_xs, p_yc, p_ys;
  logic signed [SW-1:0] base_x, base_y, sum_x, sum_y, adj_x, adj_y;
  logic signed [QW-1:0] q_x, q_y;
  logic                 ovf_x, ovf_y;

  assign p_xc = ex * cos_val;
  assign p_xs = ex * sin_val;
  assign p_yc = ey * cos_val;
  assign p_ys = ey * sin_val;

  assign base_x = SW'(center_x) <<< TRIG_FRAC_BITS;
  assign base_y = SW'(center_y) <<< TRIG_FRAC_BITS;

  assign sum_x = base_x + SW'(p_xc) - SW'(p_ys);
  assign sum_y = base_y + SW'(p_xs) + SW'(p_yc);

  // bias negative sums so the shift truncates toward zero
  assign adj_x = sum_x + (sum_x[SW-1] ? signed'(BIAS) : '0);
  assign adj_y = sum_y + (sum_y[SW-1] ? signed'(BIAS) : '0);

  assign q_x = adj_x[SW-1:TRIG_FRAC_BITS];
  assign q_y = adj_y[SW-1:TRIG_FRAC_BITS];

  // out of range when the bits above the coordinate's sign disagree with it
  assign ovf_x = !((&q_x[QW-1:COORD_BITS-1]) || !(|q_x[QW-1:COORD_BITS-1]));
  assign ovf_y = !((&q_y[QW-1:COORD_BITS-1]) || !(|q_y[QW-1:COORD_BITS-1]));

  assign rot_x = ovf_x ? (q_x[QW-1] ? LO : HI) : q_x[COORD_BITS-1:0];
  assign rot_y = ovf_y ? (q_y[QW-1] ? LO : HI) : q_y[COORD_BITS-1:0];
  assign sat   = ovf_x || ovf_y;

endmodule

// File: hdl/point_rotate_about_center.sv
// Top level of the point rotator: config registers, two-stage pipeline, handshakes.
//
// Rotates each point (in_point_x, in_point_y) about the configured center by the
// configured angle (256 steps per turn, screen y down) and returns the rotated
// point, truncated toward zero and clipped to the signed COORD_BITS range, with
// out_saturated set when either coordinate was clipped. The block takes one item
// per clock while the output is not stalled. Its result passes through the stage 1
// register, then the result register, and leaves while out_ready is high. The first
// register holds the offsets from the center with the sine and cosine looked up
// from a 65-entry quarter-wave table. The second holds the result after four
// parallel multipliers, the sums and the clip. A stalled output backs up
// into the first stage, so up to two items are held before in_ready drops.
// Configuration writes (index 0 angle, 1 center x, 2 center y; others ignored)
// are always taken (cfg_ready is high) and must be issued only while no item is
// in flight; angle uses the low 8 bits of cfg_data.
module point_rotate_about_center #(
  parameter int COORD_BITS     = 24,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_BITS-1:0]          in_point_x,
  input  logic signed [COORD_BITS-1:0]          in_point_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_BITS-1:0]          out_rotated_x,
  output logic signed [COORD_BITS-1:0]          out_rotated_y,
  output logic                                  out_saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rpac_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data
);

  localparam int EW = COORD_BITS + 1;
  localparam int TW = TRIG_FRAC_BITS + 2;

  // configuration registers
  logic [rpac_pkg::ANGLE_BITS-1:0] angle_r;
  logic signed [COORD_BITS-1:0]    center_x_r, center_y_r;

  // stage 1: offsets and trig values
  logic                   s1_valid_r, s1_valid_nxt;
  logic signed [EW-1:0]   s1_ex_r, s1_ey_r, s1_ex_nxt, s1_ey_nxt;
  logic signed [TW-1:0]   s1_sin_r, s1_cos_r, sin_val, cos_val;

  // stage 2: result register
  logic                           out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0]   rot_x_r, rot_y_r, rot_x_nxt, rot_y_nxt;
  logic                           sat_r, sat_nxt;

  logic adv1, adv2;
  logic signed [COORD_BITS-1:0] chk_x, chk_y;

  // advance the result register when empty or drained, stage 1 when it can move on
  assign adv2     = !out_valid_r || out_ready;
  assign adv1     = !s1_valid_r || adv2;
  assign in_ready = adv1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r    <= '0;
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpac_pkg::CFG_ANGLE:    angle_r    <= cfg_data[rpac_pkg::ANGLE_BITS-1:0];
        rpac_pkg::CFG_CENTER_X: center_x_r <= cfg_data;
        rpac_pkg::CFG_CENTER_Y: center_y_r <= cfg_data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  rpac_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .angle   (angle_r),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  assign s1_ex_nxt    = EW'(in_point_x) - EW'(center_x_r);
  assign s1_ey_nxt    = EW'(in_point_y) - EW'(center_y_r);
  assign s1_valid_nxt = adv1 ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // capture the item and its trig values on accept
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_ex_r  <= s1_ex_nxt;
      s1_ey_r  <= s1_ey_nxt;
      s1_sin_r <= sin_val;
      s1_cos_r <= cos_val;
    end
  end

  rpac_rotate #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .ex       (s1_ex_r),
    .ey       (s1_ey_r),
    .sin_val  (s1_sin_r),
    .cos_val  (s1_cos_r),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .rot_x    (rot_x_nxt),
    .rot_y    (rot_y_nxt),
    .sat      (sat_nxt)
  );

  assign out_valid_nxt = adv2 ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      rot_x_r <= rot_x_nxt;
      rot_y_r <= rot_y_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rotated_x = rot_x_r;
  assign out_rotated_y = rot_y_r;
  assign out_saturated = sat_r;

  // original point rebuilt from the stage 1 offset
  assign chk_x = COORD_BITS'(s1_ex_r + EW'(center_x_r));
  assign chk_y = COORD_BITS'(s1_ey_r + EW'(center_y_r));

  // a zero angle returns the point itself, unclipped
  a_zero_angle_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv2 && (angle_r == '0)) |=>
      (!out_saturated && (out_rotated_x == $past(chk_x)) && (out_rotated_y == $past(chk_y))))
    else $error("zero-angle rotation changed the point");

  // a stalled full pipeline must not take a new item
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && s1_valid_r) |-> !in_ready)
    else $error("item accepted into a full pipeline");

  // the result register fills only from a valid stage 1
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (adv2 && !s1_valid_r) |=> !out_valid_r)
    else $error("result appeared without an item in stage 1");

endmodule
